### design/gte_pkg.sv
// Shared constants and types for the graph traversal engine.
package gte_pkg;
  localparam int VERTICES_DEF = 16;
  localparam int VERTEX_SPAN = 16;
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] VCOUNT_RST = 5'd16;
  localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
  localparam logic [0:0] REG_TRAVERSAL_MODE = 1'b1;
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_TRAVERSE = 1'b1;
endpackage

### design/gte_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module gte_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### design/graph_traversal_engine.sv
// Graph traversal engine: neighbor lists and work list in RAM, BFS or DFS walker.
// Add edge: scans the source's list for the target in each direction, appending it if absent.
// Traverse: reads the neighbor list of each visited vertex and emits vertices in visit order.
// One item at a time; in_stall stays high until the item is done. A result waits in the
// output register and the walk holds on its next result while out_stall is high.
// rst_n (synchronous) clears degrees, visited marks and control; the RAMs are not cleared.
module graph_traversal_engine #(
  parameter int VERTICES = gte_pkg::VERTICES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_action,
  input  logic [3:0] in_from_vertex,
  input  logic [3:0] in_to_vertex,
  input  logic in_undirected,
  output logic out_valid,
  input  logic out_stall,
  output logic [3:0] out_vertex,
  output logic out_last,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [gte_pkg::CFG_W-1:0] cfg_data
);
  // vertex numbers are 4 bits wide, so no more than 16 vertices are ever in use
  localparam int NV = (VERTICES < gte_pkg::VERTEX_SPAN) ? VERTICES : gte_pkg::VERTEX_SPAN;
  localparam int VW = $clog2(NV);
  localparam int DW = $clog2(NV + 1);
  localparam int AW = 2 * VW;
  localparam int CW = gte_pkg::CFG_W;
  localparam int WLW = VW + DW;
  localparam logic [NV-1:0] VIS_FIRST = {{(NV-1){1'b0}}, 1'b1};

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_CHK, S_EMIT, S_NBR, S_NBR_CHK, S_NEXT, S_POP, S_DONE
  } state_t;

  state_t state_r;
  logic [CW-1:0] vcount_r;
  logic mode_r;
  logic [DW-1:0] degree_r [NV];
  logic [NV-1:0] visited_r;
  logic [VW-1:0] src_r, dst_r;
  logic second_r, und_r;
  logic [DW-1:0] idx_r;
  logic [DW-1:0] head_r, tail_r;  // BFS queue pointers; tail_r is the DFS stack depth
  logic [VW-1:0] cur_r;
  logic [VW-1:0] pend_v_r;
  logic pend_r;
  logic ov_r, ol_r;
  logic [3:0] ovx_r;

  // effective count saturated to the vertices in use
  logic [CW-1:0] n_use;
  assign n_use = (vcount_r > CW'(NV)) ? CW'(NV) : vcount_r;

  logic from_ok, to_ok;
  assign from_ok = CW'(in_from_vertex) < n_use;
  assign to_ok = CW'(in_to_vertex) < n_use;

  // list RAM
  logic l_we;
  logic [AW-1:0] l_wa, l_ra;
  logic [VW-1:0] l_wd, l_rd;
  gte_ram #(.WIDTH(VW), .DEPTH(1 << AW)) u_lists (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
  );

  // work list RAM: vertex plus next index
  logic w_we;
  logic [VW-1:0] w_wa, w_ra;
  logic [WLW-1:0] w_wd, w_rd;
  gte_ram #(.WIDTH(WLW), .DEPTH(1 << VW)) u_work (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
  );

  logic [DW-1:0] src_deg, cur_deg;
  assign src_deg = degree_r[src_r];
  assign cur_deg = degree_r[cur_r];

  logic [VW-1:0] w_vtx;
  logic [DW-1:0] w_idx;
  assign w_vtx = w_rd[VW-1:0];
  assign w_idx = w_rd[WLW-1:VW];

  logic nb_new, scan_end, walk_end, dir_done;
  assign nb_new = (CW'(l_rd) < n_use) && !visited_r[l_rd];
  assign scan_end = idx_r >= src_deg;
  assign walk_end = idx_r >= cur_deg;
  assign dir_done = (state_r == S_SCAN && scan_end) || (state_r == S_SCAN_CHK && l_rd == dst_r);

  logic out_free, load_out;
  assign out_free = !ov_r || !out_stall;
  // the held result goes out once the next one is found, or as the last at the end
  assign load_out = out_free && ((state_r == S_EMIT && pend_r) || state_r == S_DONE);

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_vertex = ovx_r;
  assign out_last = ol_r;

  always_comb begin
    l_we = 1'b0;
    l_wa = {src_r, src_deg[VW-1:0]};
    l_wd = dst_r;
    l_ra = {src_r, idx_r[VW-1:0]};
    w_we = 1'b0;
    w_wa = tail_r[VW-1:0];
    w_wd = {{DW{1'b0}}, l_rd};
    w_ra = mode_r ? VW'(tail_r - DW'(1)) : head_r[VW-1:0];
    unique case (state_r)
      S_SCAN: l_we = scan_end && (src_deg < DW'(NV));
      S_NBR: l_ra = {cur_r, idx_r[VW-1:0]};
      S_NBR_CHK: begin
        w_we = nb_new;
        // DFS saves the parent with its next index below the new top
        if (mode_r) w_wd = {DW'(idx_r + DW'(1)), cur_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vcount_r <= gte_pkg::VCOUNT_RST;
      mode_r <= 1'b0;
      for (int i = 0; i < NV; i++) degree_r[i] <= '0;
      visited_r <= '0;
      ov_r <= 1'b0;
      ol_r <= 1'b0;
      ovx_r <= '0;
      pend_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gte_pkg::REG_VERTEX_COUNT: vcount_r <= cfg_data;
          gte_pkg::REG_TRAVERSAL_MODE: mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (load_out) begin
        ov_r <= 1'b1;
        ovx_r <= 4'(pend_v_r);
        ol_r <= (state_r == S_DONE);
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            src_r <= in_from_vertex[VW-1:0];
            dst_r <= in_to_vertex[VW-1:0];
            und_r <= in_undirected;
            second_r <= 1'b0;
            idx_r <= '0;
            cur_r <= in_from_vertex[VW-1:0];
            head_r <= '0;
            tail_r <= '0;
            if (in_action == gte_pkg::ACT_ADD) begin
              if (from_ok && to_ok) state_r <= S_SCAN;
            end else if (from_ok) begin
              visited_r <= VIS_FIRST << in_from_vertex[VW-1:0];
              state_r <= S_EMIT;
            end
          end
        end
        S_SCAN, S_SCAN_CHK: begin
          if (dir_done) begin
            if (und_r && !second_r) begin
              second_r <= 1'b1; src_r <= dst_r; dst_r <= src_r; idx_r <= '0;
              state_r <= S_SCAN;
            end else state_r <= S_IDLE;
          end else if (state_r == S_SCAN) begin
            state_r <= S_SCAN_CHK;
          end else begin
            idx_r <= idx_r + DW'(1);
            state_r <= S_SCAN;
          end
          if (l_we) degree_r[src_r] <= src_deg + DW'(1);
        end
        S_EMIT: begin
          // hold the new vertex until the previous result has left
          if (!pend_r || out_free) begin
            pend_r <= 1'b1;
            pend_v_r <= cur_r;
            idx_r <= '0;
            state_r <= S_NBR;
          end
        end
        S_NBR: begin
          if (!walk_end) state_r <= S_NBR_CHK;
          else if (!mode_r) state_r <= S_NEXT;
          else if (tail_r == '0) state_r <= S_DONE;
          else state_r <= S_POP;
        end
        S_NBR_CHK: begin
          idx_r <= idx_r + DW'(1);
          if (nb_new) begin
            visited_r[l_rd] <= 1'b1;
            tail_r <= tail_r + DW'(1);
            if (mode_r) begin
              cur_r <= l_rd;
              state_r <= S_EMIT;
            end else state_r <= S_NBR;
          end else state_r <= S_NBR;
        end
        S_NEXT: state_r <= (head_r == tail_r) ? S_DONE : S_POP;
        S_POP: begin
          // w_rd holds the queue head or the entry below the stack top
          cur_r <= w_vtx;
          if (mode_r) begin
            idx_r <= w_idx;
            tail_r <= tail_r - DW'(1);
            state_r <= S_NBR;
          end else begin
            head_r <= head_r + DW'(1);
            state_r <= S_EMIT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            pend_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
